FILE: hw/rtl/htpi_pkg.sv
// Shared constants and types for the hit to pad index mapper.
package htpi_pkg;

    localparam int unsigned ANG_W   = 32;
    localparam int unsigned RAD_FRAC = 12;
    localparam int unsigned CFG_W   = 19;
    localparam int unsigned SEGC_W  = 9;
    localparam int unsigned PAD_W   = 16;
    localparam int unsigned ST_W    = 2;
    localparam int unsigned PHI_PRE = 40;
    localparam int unsigned PHI_XW  = 42;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_OUTSIDE   = 2'd1,
        ST_SEG_UNSET = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        REG_R_INNER      = 3'd0,
        REG_R_OUTER      = 3'd1,
        REG_Z_DISTANCE   = 3'd2,
        REG_R_SEGMENTS   = 3'd3,
        REG_PHI_SEGMENTS = 3'd4
    } t_reg_idx;

    localparam logic [ANG_W-1:0] ATAN_TURN [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

FILE: hw/rtl/htpi_cordic.sv
// Pipelined CORDIC vectoring unit returning the angle as a fraction of a turn.
module htpi_cordic #(
    parameter int unsigned XW     = 42,
    parameter int unsigned STAGES = 24
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [XW-1:0]         i_x,
    input  logic signed [XW-1:0]         i_y,
    input  logic [htpi_pkg::ANG_W-1:0]   i_ang,
    output logic [htpi_pkg::ANG_W-1:0]   o_ang
);
    import htpi_pkg::*;

    logic signed [XW-1:0] r_x [STAGES];
    logic signed [XW-1:0] r_y [STAGES];
    logic [ANG_W-1:0]     r_a [STAGES];
    logic [ANG_W-1:0]     r_ang_out;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= i_x;
            r_y[0] <= i_y;
            r_a[0] <= i_ang;
        end
    end

    for (genvar k = 0; k < STAGES - 1; k++) begin : g_stage
        logic signed [XW-1:0] n_x, n_y;
        logic [ANG_W-1:0]     n_a;
        always_comb begin
            if (r_y[k] >= 0) begin
                n_x = r_x[k] + (r_y[k] >>> k);
                n_y = r_y[k] - (r_x[k] >>> k);
                n_a = r_a[k] + ATAN_TURN[k];
            end else begin
                n_x = r_x[k] - (r_y[k] >>> k);
                n_y = r_y[k] + (r_x[k] >>> k);
                n_a = r_a[k] - ATAN_TURN[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k+1] <= n_x;
                r_y[k+1] <= n_y;
                r_a[k+1] <= n_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_y[STAGES-1] >= 0) begin
                r_ang_out <= r_a[STAGES-1] + ATAN_TURN[STAGES-1];
            end else begin
                r_ang_out <= r_a[STAGES-1] - ATAN_TURN[STAGES-1];
            end
        end
    end

    assign o_ang = r_ang_out;

endmodule

FILE: hw/rtl/htpi_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module htpi_sqrt #(
    parameter int unsigned NB = 32
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [2*NB-1:0]   i_n,
    output logic [NB-1:0]     o_root
);
    localparam int unsigned RW = NB + 2;

    logic [2*NB-1:0] r_n    [NB];
    logic [RW-1:0]   r_rem  [NB];
    logic [NB-1:0]   r_root [NB];
    logic [NB-1:0]   r_out;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]    <= i_n;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
        end
    end

    for (genvar k = 0; k < NB; k++) begin : g_stage
        logic [RW+1:0] w_rem2, w_trial;
        logic [RW-1:0] n_rem;
        logic [NB-1:0] n_root;
        always_comb begin
            w_rem2  = {r_rem[k], r_n[k][2*NB-1 -: 2]};
            w_trial = (RW+2)'({r_root[k], 2'b01});
            if (w_rem2 >= w_trial) begin
                n_rem  = RW'(w_rem2 - w_trial);
                n_root = {r_root[k][NB-2:0], 1'b1};
            end else begin
                n_rem  = RW'(w_rem2);
                n_root = {r_root[k][NB-2:0], 1'b0};
            end
        end
        if (k < NB - 1) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_n[k+1]    <= {r_n[k][2*NB-3:0], 2'b00};
                    r_rem[k+1]  <= n_rem;
                    r_root[k+1] <= n_root;
                end
            end
        end else begin : g_last
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_out <= n_root;
                end
            end
        end
    end

    assign o_root = r_out;

endmodule

FILE: hw/rtl/hit_to_pad_index_top.sv
// Top level of the hit to pad index mapper: config registers and the item pipeline.
// Maps a hit (x, y) to azimuth sector and equal-theta ring, giving
// pad = sector * ring_count + ring and a status (0 ok, 1 radius outside
// the window, 2 segmentation unset; pad 0 on error). One item is accepted per clock
// while the pipeline is not held; the path runs through the square-root pipeline
// (COORD_BITS+12 stages) followed by the theta CORDIC pipeline and the ring divider.
// The whole pipeline holds while the output register is full and not taken. Write
// registers only while no item is in flight.
module hit_to_pad_index_top #(
    parameter int unsigned COORD_BITS    = 20,
    parameter int unsigned ANGLE_BITS    = 24,
    parameter int unsigned CORDIC_STAGES = 24,
    parameter int unsigned MAX_SEGMENTS  = 256
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_s_tvalid,
    output logic                                      o_s_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]         i_s_tdata,  // x_pos, y_pos
    output logic                                      o_m_tvalid,
    input  logic                                      i_m_tready,
    output logic [htpi_pkg::PAD_W-1:0]                o_m_tdata,  // pad
    output logic [htpi_pkg::ST_W-1:0]                 o_m_tuser,  // status
    input  logic                                      i_psel,
    input  logic                                      i_penable,
    input  logic                                      i_pwrite,
    input  logic [4:0]                                i_paddr,
    input  logic [31:0]                               i_pwdata,
    output logic [31:0]                               o_prdata,
    output logic                                      o_pready
);
    import htpi_pkg::*;

    localparam int unsigned CB    = COORD_BITS;
    localparam int unsigned NB    = CB + RAD_FRAC;
    localparam int unsigned SEG_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int unsigned CW    = SEG_W + 1;
    localparam int unsigned TXW   = ((NB > CFG_W + RAD_FRAC) ? NB : CFG_W + RAD_FRAC) + 3;
    localparam int unsigned NW    = ANGLE_BITS + SEG_W;
    localparam int unsigned L     = NB + CORDIC_STAGES + SEG_W + 7;
    localparam int unsigned DP    = NB + SEG_W + 3;
    localparam int unsigned DS    = L - 4;

    // configuration
    logic [CFG_W-1:0]  r_r_inner, r_r_outer, r_z_distance;
    logic [SEGC_W-1:0] r_r_segments, r_phi_segments;
    logic [2:0]        w_idx;

    assign w_idx    = i_paddr[4:2];
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_inner      <= '0;
            r_r_outer      <= '0;
            r_z_distance   <= CFG_W'(1);
            r_r_segments   <= '0;
            r_phi_segments <= '0;
        end else if (i_psel && i_penable && i_pwrite) begin
            case (w_idx)
                REG_R_INNER:      r_r_inner      <= i_pwdata[CFG_W-1:0];
                REG_R_OUTER:      r_r_outer      <= i_pwdata[CFG_W-1:0];
                REG_Z_DISTANCE:   r_z_distance   <= i_pwdata[CFG_W-1:0];
                REG_R_SEGMENTS:   r_r_segments   <= i_pwdata[SEGC_W-1:0];
                REG_PHI_SEGMENTS: r_phi_segments <= i_pwdata[SEGC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_R_INNER:      o_prdata = 32'(r_r_inner);
            REG_R_OUTER:      o_prdata = 32'(r_r_outer);
            REG_Z_DISTANCE:   o_prdata = 32'(r_z_distance);
            REG_R_SEGMENTS:   o_prdata = 32'(r_r_segments);
            REG_PHI_SEGMENTS: o_prdata = 32'(r_phi_segments);
            default:          o_prdata = '0;
        endcase
    end

    logic [CW-1:0] w_rcnt, w_pcnt;
    logic          w_unset;
    assign w_rcnt  = (r_r_segments > SEGC_W'(MAX_SEGMENTS)) ? CW'(MAX_SEGMENTS)
                                                            : CW'(r_r_segments);
    assign w_pcnt  = (r_phi_segments > SEGC_W'(MAX_SEGMENTS)) ? CW'(MAX_SEGMENTS)
                                                              : CW'(r_phi_segments);
    assign w_unset = (r_r_segments == '0) || (r_phi_segments == '0);

    logic [2*CFG_W-1:0] r_rin2, r_rout2;
    always_ff @(posedge i_clk) begin
        r_rin2  <= r_r_inner * r_r_inner;
        r_rout2 <= r_r_outer * r_r_outer;
    end

    // pipeline control
    logic         w_en;
    logic [L:1]   r_vld;
    assign w_en       = !r_vld[L] || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_vld[L];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[L-1:1], i_s_tvalid};
        end
    end

    // stage 1..3: capture, square, window test
    logic signed [CB-1:0] r_x, r_y;
    logic [2*CB-1:0]      r_xx, r_yy, r_r2;
    t_status              r_st3;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x  <= i_s_tdata[CB-1:0];
            r_y  <= i_s_tdata[2*CB-1:CB];
            r_xx <= (2*CB)'(r_x * r_x);
            r_yy <= (2*CB)'(r_y * r_y);
            r_r2 <= r_xx + r_yy;
            if (w_unset) begin
                r_st3 <= ST_SEG_UNSET;
            end else if ((64'(r_xx) + 64'(r_yy) < 64'(r_rin2)) ||
                         (64'(r_xx) + 64'(r_yy) >= 64'(r_rout2))) begin
                r_st3 <= ST_OUTSIDE;
            end else begin
                r_st3 <= ST_OK;
            end
        end
    end

    // azimuth
    logic signed [PHI_XW-1:0] w_sx, w_sy, w_px, w_py;
    logic [ANG_W-1:0]         w_pstart, w_phi_ang;
    assign w_sx = PHI_XW'(r_x) <<< (PHI_PRE - CB);
    assign w_sy = PHI_XW'(r_y) <<< (PHI_PRE - CB);
    assign w_px = r_x[CB-1] ? -w_sx : w_sx;
    assign w_py = r_x[CB-1] ? -w_sy : w_sy;
    assign w_pstart = r_x[CB-1] ? 32'h8000_0000 : '0;

    htpi_cordic #(.XW(PHI_XW), .STAGES(CORDIC_STAGES)) u_phi (
        .i_clk (i_clk), .i_en (w_en), .i_x (w_px), .i_y (w_py),
        .i_ang (w_pstart), .o_ang (w_phi_ang)
    );

    logic [ANGLE_BITS+CW-1:0] w_pprod;
    logic [CW-1:0]            w_pidx;
    logic [SEG_W-1:0]         r_phi_dly [DP+1];
    assign w_pprod = w_phi_ang[ANG_W-1 -: ANGLE_BITS] * w_pcnt;
    assign w_pidx  = w_pprod[ANGLE_BITS +: CW];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_phi_dly[0] <= (w_pidx > w_pcnt - CW'(1)) ? SEG_W'(w_pcnt - CW'(1))
                                                       : SEG_W'(w_pidx);
            for (int i = 1; i <= DP; i++) begin
                r_phi_dly[i] <= r_phi_dly[i-1];
            end
        end
    end

    // status delay
    t_status r_st_dly [DS];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_st_dly[0] <= r_st3;
            for (int i = 1; i < DS; i++) begin
                r_st_dly[i] <= r_st_dly[i-1];
            end
        end
    end

    // radius and polar angles
    logic [NB-1:0]  w_rf;
    logic [ANG_W-1:0] w_th_ang, w_tin_ang, w_tout_ang;
    logic signed [TXW-1:0] w_zx;

    htpi_sqrt #(.NB(NB)) u_sqrt (
        .i_clk (i_clk), .i_en (w_en), .i_n ({r_r2, (2*RAD_FRAC)'(0)}), .o_root (w_rf)
    );

    assign w_zx = TXW'({r_z_distance, RAD_FRAC'(0)});

    htpi_cordic #(.XW(TXW), .STAGES(CORDIC_STAGES)) u_th (
        .i_clk (i_clk), .i_en (w_en), .i_x (w_zx), .i_y (TXW'(w_rf)),
        .i_ang ('0), .o_ang (w_th_ang)
    );
    htpi_cordic #(.XW(TXW), .STAGES(CORDIC_STAGES)) u_tin (
        .i_clk (i_clk), .i_en (w_en), .i_x (w_zx),
        .i_y (TXW'({r_r_inner, RAD_FRAC'(0)})), .i_ang ('0), .o_ang (w_tin_ang)
    );
    htpi_cordic #(.XW(TXW), .STAGES(CORDIC_STAGES)) u_tout (
        .i_clk (i_clk), .i_en (w_en), .i_x (w_zx),
        .i_y (TXW'({r_r_outer, RAD_FRAC'(0)})), .i_ang ('0), .o_ang (w_tout_ang)
    );

    logic [ANGLE_BITS-1:0] w_th, w_tin, w_tout;
    assign w_th   = (w_th_ang[31:30] == 2'b11)   ? '0 : w_th_ang[ANG_W-1 -: ANGLE_BITS];
    assign w_tin  = (w_tin_ang[31:30] == 2'b11)  ? '0 : w_tin_ang[ANG_W-1 -: ANGLE_BITS];
    assign w_tout = (w_tout_ang[31:30] == 2'b11) ? '0 : w_tout_ang[ANG_W-1 -: ANGLE_BITS];

    // ring divider
    logic [NW-1:0]         r_dn [SEG_W+1];
    logic [ANGLE_BITS-1:0] r_dd [SEG_W+1];
    logic [SEG_W-1:0]      r_dq [SEG_W+1];
    logic                  r_dz [SEG_W+1];
    logic                  r_df [SEG_W+1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dn[0] <= NW'((w_th - w_tin) * w_rcnt);
            r_dd[0] <= w_tout - w_tin;
            r_dq[0] <= '0;
            r_dz[0] <= (w_tout <= w_tin) || (w_th <= w_tin);
            r_df[0] <= (w_th >= w_tout);
        end
    end

    for (genvar k = 0; k < SEG_W; k++) begin : g_div
        localparam int unsigned B = SEG_W - 1 - k;
        logic [NW-1:0] w_sub;
        assign w_sub = NW'(r_dd[k]) << B;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dd[k+1] <= r_dd[k];
                r_dz[k+1] <= r_dz[k];
                r_df[k+1] <= r_df[k];
                if (r_dn[k] >= w_sub) begin
                    r_dn[k+1] <= r_dn[k] - w_sub;
                    r_dq[k+1] <= r_dq[k] | (SEG_W'(1) << B);
                end else begin
                    r_dn[k+1] <= r_dn[k];
                    r_dq[k+1] <= r_dq[k];
                end
            end
        end
    end

    // output register
    logic [SEG_W-1:0]      w_ring;
    logic [SEG_W+CW:0]     w_pad;
    logic [PAD_W-1:0]      r_pad;
    t_status               r_st;

    assign w_ring = r_dz[SEG_W] ? '0 :
                    r_df[SEG_W] ? SEG_W'(w_rcnt - CW'(1)) : r_dq[SEG_W];
    assign w_pad  = (SEG_W+CW+1)'(r_phi_dly[DP] * w_rcnt) + (SEG_W+CW+1)'(w_ring);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_st  <= r_st_dly[DS-1];
            r_pad <= (r_st_dly[DS-1] == ST_OK) ? PAD_W'(w_pad) : '0;
        end
    end

    assign o_m_tdata = r_pad;
    assign o_m_tuser = r_st;

endmodule

FILE: hw/rtl/htpi_checker.sv
// Port-level checks for the hit to pad index mapper, bound to the top level.
module htpi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        o_pready
);
    import htpi_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output item dropped while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != ST_OK) |-> (o_m_tdata == '0))
        else $error("nonzero pad with error status");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid || i_m_tready) |-> o_s_tready)
        else $error("input stalled with free output");

    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid && o_pready)
        else $error("output valid after reset");

endmodule

bind hit_to_pad_index_top htpi_checker u_htpi_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_pready   (o_pready)
);

FILE: tb/sv/hit_to_pad_index_top_tb.sv
// Testbench for the hit to pad index mapper: directed and random hits checked by a predictor.
`timescale 1ns / 1ps

module hit_to_pad_index_top_tb;
    import htpi_pkg::*;

    localparam int unsigned ANGLE_BITS = 24;
    localparam int unsigned STAGES     = 24;
    localparam int unsigned SEG_MAX    = 256;
    localparam int          CYCLE_LIMIT = 600000;
    localparam int          DRAIN_GAP   = 100;

    typedef struct packed {
        logic [PAD_W-1:0] pad;
        t_status          status;
    } t_pad_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        i_psel;
    logic        i_penable;
    logic        i_pwrite;
    logic [4:0]  i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic        o_pready;

    hit_to_pad_index_top DUT (.*);

    bit [18:0] r_in_q, r_out_q, z_dist_q;
    bit [8:0]  ring_cnt_q, sect_cnt_q;

    t_pad_result pending_pads[$];
    bit  steady_flow;
    int  n_mismatch, n_items, n_ok, n_outside, n_unset, cycle_cnt;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit [31:0] cordic_turns(longint x, longint y, bit [31:0] start);
        bit [31:0] ang;
        longint dx, dy;
        ang = start;
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; ang += ATAN_TURN[i];
            end else begin
                x -= dx; y += dy; ang -= ATAN_TURN[i];
            end
        end
        return ang;
    endfunction

    function automatic longint theta_turns(longint unsigned rfix);
        bit [31:0] a;
        a = cordic_turns(longint'(z_dist_q) <<< RAD_FRAC, longint'(rfix), 32'd0);
        if (a >= 32'hC000_0000) a = 32'd0;
        return longint'(a >> (32 - ANGLE_BITS));
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic t_pad_result map_hit(logic signed [19:0] xp, logic signed [19:0] yp);
        t_pad_result r;
        longint x, y, sx, sy, rings, sects, r2, phi_idx, ring, th, tin, tout;
        bit [31:0] start;
        x = xp;
        y = yp;
        r.pad = '0;
        r.status = ST_OK;
        rings = ring_cnt_q;
        sects = sect_cnt_q;
        if (rings == 0 || sects == 0) begin
            r.status = ST_SEG_UNSET;
            return r;
        end
        if (rings > SEG_MAX) rings = SEG_MAX;
        if (sects > SEG_MAX) sects = SEG_MAX;
        r2 = x * x + y * y;
        if (r2 < longint'(r_in_q) * r_in_q || r2 >= longint'(r_out_q) * r_out_q) begin
            r.status = ST_OUTSIDE;
            return r;
        end
        sx = x <<< 20;
        sy = y <<< 20;
        start = 32'd0;
        if (sx < 0) begin
            sx = -sx; sy = -sy; start = 32'h8000_0000;
        end
        phi_idx = (longint'(cordic_turns(sx, sy, start) >> (32 - ANGLE_BITS)) * sects)
                  >> ANGLE_BITS;
        if (phi_idx > sects - 1) phi_idx = sects - 1;
        th   = theta_turns(int_sqrt(longint'(r2) << (2 * RAD_FRAC)));
        tin  = theta_turns(longint'(r_in_q) << RAD_FRAC);
        tout = theta_turns(longint'(r_out_q) << RAD_FRAC);
        if (tout <= tin || th <= tin) ring = 0;
        else ring = ((th - tin) * rings) / (tout - tin);
        if (ring > rings - 1) ring = rings - 1;
        r.pad = 16'((phi_idx * rings + ring) & 16'hFFFF);
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) i_m_tready <= steady_flow || ($urandom % 100 >= 9);
    end

    always @(posedge i_clk) begin
        t_pad_result exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_pads.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected item pad=%0d status=%0d", o_m_tdata, o_m_tuser);
            end else begin
                exp_r = pending_pads.pop_front();
                if (o_m_tdata !== exp_r.pad || o_m_tuser !== exp_r.status) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: pad exp %0d got %0d, status exp %0d got %0d",
                                 exp_r.pad, o_m_tdata, exp_r.status, o_m_tuser);
                end
            end
        end
    end

    task automatic write_reg(t_reg_idx idx, bit [31:0] value);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= 5'(idx * 4);
        i_pwdata  <= value;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        case (idx)
            REG_R_INNER:      r_in_q     = value[18:0];
            REG_R_OUTER:      r_out_q    = value[18:0];
            REG_Z_DISTANCE:   z_dist_q   = value[18:0];
            REG_R_SEGMENTS:   ring_cnt_q = value[8:0];
            REG_PHI_SEGMENTS: sect_cnt_q = value[8:0];
            default: ;
        endcase
    endtask

    task automatic set_station(int rin, int rout, int z, int rings, int sects);
        write_reg(REG_R_INNER, rin);
        write_reg(REG_R_OUTER, rout);
        write_reg(REG_Z_DISTANCE, z);
        write_reg(REG_R_SEGMENTS, rings);
        write_reg(REG_PHI_SEGMENTS, sects);
    endtask

    task automatic send_hit(logic signed [19:0] x, logic signed [19:0] y);
        t_pad_result r;
        r = map_hit(x, y);
        while (!steady_flow && ($urandom % 100 < 9)) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {y, x};
        do @(posedge i_clk); while (!o_s_tready);
        pending_pads = {pending_pads, r};
        n_items++;
        case (r.status)
            ST_OK:      n_ok++;
            ST_OUTSIDE: n_outside++;
            default:    n_unset++;
        endcase
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_pads.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic test_unset_segmentation();
        send_hit(20'sd0, 20'sd0);
        send_hit(-20'sd524288, 20'sd524287);
        drain();
        set_station(0, 524287, 1, 0, 16);
        send_hit(20'sd1000, 20'sd1000);
        drain();
    endtask

    task automatic test_extremes();
        set_station(0, 524287, 1, 256, 256);
        send_hit(20'sd0, 20'sd0);
        send_hit(20'sd524287, 20'sd0);
        send_hit(20'sd0, 20'sd524287);
        send_hit(-20'sd524288, 20'sd0);
        send_hit(-20'sd524288, -20'sd524288);
        send_hit(-20'sd1, 20'sd0);
        send_hit(20'sd1, -20'sd1);
        send_hit(-20'sd300000, -20'sd300000);
        send_hit(20'sd300000, -20'sd300000);
        send_hit(20'sd0, -20'sd1);
        drain();
        set_station(0, 524287, 0, 511, 300);
        send_hit(20'sd1, 20'sd0);
        send_hit(-20'sd370000, 20'sd370000);
        send_hit(20'sd0, -20'sd524287);
        drain();
        set_station(1000, 500, 100, 8, 8);
        send_hit(20'sd700, 20'sd0);
        send_hit(20'sd0, 20'sd0);
        drain();
        set_station(1000, 1000, 100, 8, 8);
        send_hit(20'sd1000, 20'sd0);
        drain();
    endtask

    task automatic test_random_hits();
        int rin, rout, lim;
        for (int ph = 0; ph < 8; ph++) begin
            rin  = $urandom_range(0, 200000);
            rout = rin + $urandom_range(0, 324287);
            if (ph == 0) begin
                rin = 0; rout = 524287;
            end
            set_station(rin, rout,
                        ($urandom % 6 == 0) ? $urandom_range(0, 3) : $urandom_range(1, 524287),
                        ($urandom % 10 == 0) ? 0 : $urandom_range(1, 511),
                        ($urandom % 10 == 0) ? 0 : $urandom_range(1, 511));
            lim = rout * 7 / 10 + 1;
            steady_flow = (ph == 3);
            for (int k = 0; k < 250; k++) begin
                if ($urandom % 8 == 0)
                    send_hit(20'($urandom), 20'($urandom));
                else
                    send_hit(20'(int'($urandom_range(0, 2 * lim)) - lim),
                             20'(int'($urandom_range(0, 2 * lim)) - lim));
            end
            steady_flow = 1'b0;
            drain();
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_m_tready <= 1'b0;
        i_psel     <= 1'b0;
        i_penable  <= 1'b0;
        i_pwrite   <= 1'b0;
        i_paddr    <= '0;
        i_pwdata   <= '0;
        cycle_cnt  <= 0;
        r_in_q = 0; r_out_q = 0; z_dist_q = 1; ring_cnt_q = 0; sect_cnt_q = 0;
        steady_flow = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_unset_segmentation();
        test_extremes();
        test_random_hits();
        $display("%0d hits mapped over directed and random station settings", n_items);
        $display("ok %0d, outside window %0d, segmentation unset %0d, mismatches %0d",
                 n_ok, n_outside, n_unset, n_mismatch);
        if (n_mismatch == 0 && pending_pads.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
